// ===== hdl/hpe_pkg.sv =====
package hpe_pkg;

  localparam int ACC_W = 64;
  localparam int X_W   = 32;
  localparam int TC_W  = 7;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_EVAL = 1'b1;

  localparam logic       REG_TERM_COUNT   = 1'b0;
  localparam logic [TC_W-1:0] TERM_COUNT_RESET = 7'd1;

  localparam logic [ACC_W-1:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] S64_MIN_MAG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic               op;
    logic [5:0]         coeff_index;
    logic [31:0]        coeff_value;
    logic signed [31:0] x_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] poly_result;
    logic               overflow;
  } out_item_t;

  // one phase of a horner step per cycle
  typedef struct packed {
    logic start;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic round;
    logic add;
  } step_ctrl_t;

endpackage

// ===== hdl/hpe_coeff_mem.sv =====
module hpe_coeff_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/hpe_step_unit.sv =====
module hpe_step_unit #(
  parameter int FRAC_BITS = 16,
  parameter int COEFF_W   = 32
) (
  input  logic                clk,
  input  hpe_pkg::step_ctrl_t ctrl,
  input  logic signed [31:0]  x_value,
  input  logic [COEFF_W-1:0]  coeff,
  output logic signed [63:0]  acc,
  output logic                ovf
);
  import hpe_pkg::*;

  localparam logic [95:0] REM_MASK   = (96'(1) << FRAC_BITS) - 96'(1);
  localparam logic [63:0] TERM_LIMIT = S64_MAX >> FRAC_BITS;

  logic [31:0] ux;
  logic        xneg;
  logic [63:0] ua;
  logic        neg;
  logic [63:0] prod_lo;
  logic [63:0] prod_hi;
  logic [95:0] wide;
  logic [63:0] prod;

  logic [63:0] acc_bits;
  logic        aneg;
  logic [63:0] ua_next;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [95:0] wide_next;
  logic [95:0] quot;
  logic        rnd;
  logic [95:0] quot_inc;
  logic [63:0] prod_next;
  logic        psat;
  logic [63:0] coeff64;
  logic [63:0] term;
  logic        tsat;
  logic [64:0] sum65;
  logic        asat;
  logic [63:0] acc_next;

  always_comb begin
    acc_bits = acc;
    aneg     = acc_bits[63];
    ua_next  = aneg ? (64'd0 - acc_bits) : acc_bits;
    mul_a    = ctrl.mul_lo ? ua_next[31:0] : ua[63:32];
    mul_p    = 64'(mul_a) * 64'(ux);

    wide_next = {32'd0, prod_lo} + {prod_hi, 32'd0};

    // floor toward minus infinity on the magnitude form
    quot     = wide >> FRAC_BITS;
    rnd      = neg && ((wide & REM_MASK) != 96'd0);
    quot_inc = quot + 96'(rnd);
    psat     = 1'b0;
    if (!neg) begin
      if (quot_inc > {32'd0, S64_MAX}) begin
        prod_next = S64_MAX;
        psat      = 1'b1;
      end else begin
        prod_next = quot_inc[63:0];
      end
    end else begin
      if (quot_inc > {32'd0, S64_MIN_MAG}) begin
        prod_next = S64_MIN_MAG;
        psat      = 1'b1;
      end else begin
        prod_next = 64'd0 - quot_inc[63:0];
      end
    end

    coeff64 = 64'(coeff);
    if (coeff64 > TERM_LIMIT) begin
      term = S64_MAX;
      tsat = 1'b1;
    end else begin
      term = coeff64 << FRAC_BITS;
      tsat = 1'b0;
    end

    // term is never negative, so only the upper bound can be crossed
    sum65    = {prod[63], prod} + {1'b0, term};
    asat     = !sum65[64] && sum65[63];
    acc_next = asat ? S64_MAX : sum65[63:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc  <= '0;
      ovf  <= 1'b0;
      xneg <= x_value[31];
      ux   <= x_value[31] ? (32'd0 - x_value) : x_value;
    end
    if (ctrl.mul_lo) begin
      prod_lo <= mul_p;
      ua      <= ua_next;
      neg     <= aneg ^ xneg;
    end
    if (ctrl.mul_hi) begin
      prod_hi <= mul_p;
    end
    if (ctrl.sum) begin
      wide <= wide_next;
    end
    if (ctrl.round) begin
      prod <= prod_next;
      if (psat) begin
        ovf <= 1'b1;
      end
    end
    if (ctrl.add) begin
      acc <= acc_next;
      if (tsat || asat) begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/horner_polynomial_evaluator_core.sv =====
// Horner evaluator: a load item (op 0) writes one coefficient into the table if its
// coeff_index is below MAX_TERMS; an evaluate item (op 1) walks term_count coefficients
// (clamped to MAX_TERMS) from the top index down, each step going through one shared
// 32x32 multiplier (low half, high half, partial-product sum, floor and saturate,
// coefficient add); item_stall stays high until the result is registered. After reset
// the table is zeroed by a sweep over all MAX_TERMS entries during which no item is taken;
// the APB port works throughout. Result is Q47.16 by default with a sticky saturation flag.
module horner_polynomial_evaluator_core #(
  parameter int MAX_TERMS   = 64,
  parameter int COEFF_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  hpe_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output hpe_pkg::out_item_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hpe_pkg::*;

  localparam int CW = (COEFF_WIDTH < 32) ? COEFF_WIDTH : 32;
  localparam int AW = $clog2(MAX_TERMS);
  localparam int NW = $clog2(MAX_TERMS + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_MUL_HI = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;
  localparam logic [2:0] ST_ROUND  = 3'd5;
  localparam logic [2:0] ST_ADD    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [AW-1:0]   clr_addr;
  logic [NW-1:0]   remaining;
  logic [NW-1:0]   rem_m1;
  logic [NW-1:0]   tc_clamped;
  logic [TC_W-1:0] term_count;

  logic            item_take;
  logic            load_take;
  logic            eval_take;
  logic            result_free;
  step_ctrl_t      ctrl;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [CW-1:0]   wr_data;
  logic [CW-1:0]   rd_data;

  logic signed [63:0] acc;
  logic               ovf;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TERM_COUNT) ? 32'(term_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TERM_COUNT) begin
      term_count <= pwdata[TC_W-1:0];
    end
  end

  assign item_stall  = (state != ST_IDLE);
  assign item_take   = item_valid && !item_stall;
  assign load_take   = item_take && item.op == OP_LOAD;
  assign eval_take   = item_take && item.op == OP_EVAL;
  assign result_free = !result_valid || !result_stall;
  assign rem_m1      = remaining - NW'(1);
  assign tc_clamped  = (32'(term_count) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(term_count);

  always_comb begin
    ctrl        = '0;
    ctrl.start  = eval_take;
    ctrl.mul_lo = (state == ST_MUL_LO);
    ctrl.mul_hi = (state == ST_MUL_HI);
    ctrl.sum    = (state == ST_SUM);
    ctrl.round  = (state == ST_ROUND);
    ctrl.add    = (state == ST_ADD);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_TERMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (eval_take) begin
          state_next = (tc_clamped == '0) ? ST_DONE : ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_ADD;
      ST_ADD: begin
        state_next = (remaining == NW'(1)) ? ST_DONE : ST_MUL_LO;
      end
      ST_DONE: begin
        if (result_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      remaining    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (eval_take) begin
        remaining <= tc_clamped;
      end else if (state == ST_ADD) begin
        remaining <= rem_m1;
      end
      if (state == ST_DONE && result_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && result_free) begin
      result.poly_result <= acc;
      result.overflow    <= ovf;
    end
  end

  // clear sweep and loads share the write port
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = load_take && (32'(item.coeff_index) < MAX_TERMS);
      wr_addr = AW'(item.coeff_index);
      wr_data = item.coeff_value[CW-1:0];
    end
  end

  hpe_coeff_mem #(
    .DEPTH (MAX_TERMS),
    .WIDTH (CW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.mul_lo),
    .rd_addr (rem_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  hpe_step_unit #(
    .FRAC_BITS (FRAC_BITS),
    .COEFF_W   (CW)
  ) u_step (
    .clk     (clk),
    .ctrl    (ctrl),
    .x_value (item.x_value),
    .coeff   (rd_data),
    .acc     (acc),
    .ovf     (ovf)
  );

endmodule
